### hdl/rv32ie_pkg.sv
`default_nettype none

package rv32ie_pkg;

	// Major opcodes
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_OPIMM  = 7'h13;
	localparam logic [6:0] OPC_OP     = 7'h33;

	// funct7 codes
	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;

	// funct3 codes
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	localparam logic [2:0] F3_B    = 3'd0;
	localparam logic [2:0] F3_H    = 3'd1;
	localparam logic [2:0] F3_W    = 3'd2;
	localparam logic [2:0] F3_BU   = 3'd4;
	localparam logic [2:0] F3_HU   = 3'd5;

	// Memory request codes
	localparam logic [3:0] MOP_NONE = 4'd0;
	localparam logic [3:0] MOP_LB   = 4'd1;
	localparam logic [3:0] MOP_LH   = 4'd2;
	localparam logic [3:0] MOP_LW   = 4'd3;
	localparam logic [3:0] MOP_LBU  = 4'd4;
	localparam logic [3:0] MOP_LHU  = 4'd5;
	localparam logic [3:0] MOP_SB   = 4'd6;
	localparam logic [3:0] MOP_SH   = 4'd7;
	localparam logic [3:0] MOP_SW   = 4'd8;

	// Instruction class after decode
	typedef enum logic [3:0] {
		CLS_LUI,
		CLS_AUIPC,
		CLS_JAL,
		CLS_JALR,
		CLS_BRANCH,
		CLS_LOAD,
		CLS_STORE,
		CLS_ALU,
		CLS_ILLEGAL
	} cls_t;

endpackage

`default_nettype wire

### hdl/rv32ie_in_if.sv
`default_nettype none

// Instruction word channel
interface rv32ie_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] instr_word;
	logic [31:0] cur_pc;
	logic [31:0] src1_value;
	logic [31:0] src2_value;

	modport source (output valid, output instr_word, output cur_pc,
		output src1_value, output src2_value, input ready);
	modport sink (input valid, input instr_word, input cur_pc,
		input src1_value, input src2_value, output ready);
endinterface

`default_nettype wire

### hdl/rv32ie_out_if.sv
`default_nettype none

// Execute result channel
interface rv32ie_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  dest_index;
	logic        dest_write;
	logic [31:0] dest_value;
	logic [31:0] next_pc;
	logic [3:0]  mem_op;
	logic [31:0] mem_address;
	logic [31:0] mem_write_data;
	logic        illegal;

	modport source (output valid, output dest_index, output dest_write,
		output dest_value, output next_pc, output mem_op, output mem_address,
		output mem_write_data, output illegal, input ready);
	modport sink (input valid, input dest_index, input dest_write,
		input dest_value, input next_pc, input mem_op, input mem_address,
		input mem_write_data, input illegal, output ready);
endinterface

`default_nettype wire

### hdl/rv32i_integer_execute_unit.sv
// RV32I execute unit: decode, execute and result stages.
// An accepted word passes the decode, execute and result stage registers in turn.
// Throughput: one word per cycle while the output is not stalled.
// The third stage register is the output. A waiting result holds that stage, and an
// earlier stage stalls only once every stage after it is full. Reset clears the stage
// valid bits only; the pipeline starts empty.
`default_nettype none

module rv32i_integer_execute_unit
	import rv32ie_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	rv32ie_in_if.sink    instr,
	rv32ie_out_if.source result
);

	// Stage handshake
	logic valid_s1, valid_s2, valid_s3;
	logic ready_s1, ready_s2, ready_s3;

	assign ready_s3    = !valid_s3 || result.ready;
	assign ready_s2    = !valid_s2 || ready_s3;
	assign ready_s1    = !valid_s1 || ready_s2;
	assign instr.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= instr.valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	// ---------------- Stage 1: decode ----------------
	logic [31:0] iw;
	logic [6:0]  opc, f7;
	logic [2:0]  f3;
	logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
	cls_t        cls_d;
	logic [3:0]  mop_d;
	logic [31:0] base_d, imm_d, opb_d, wdata_d;
	logic        alt_d;

	assign iw    = instr.instr_word;
	assign opc   = iw[6:0];
	assign f3    = iw[14:12];
	assign f7    = iw[31:25];
	assign imm_i = {{20{iw[31]}}, iw[31:20]};
	assign imm_s = {{20{iw[31]}}, iw[31:25], iw[11:7]};
	assign imm_b = {{19{iw[31]}}, iw[31], iw[7], iw[30:25], iw[11:8], 1'b0};
	assign imm_j = {{11{iw[31]}}, iw[31], iw[19:12], iw[20], iw[30:21], 1'b0};
	assign imm_u = {iw[31:12], 12'h000};

	always_comb begin
		cls_d   = CLS_ILLEGAL;
		mop_d   = MOP_NONE;
		base_d  = '0;
		imm_d   = '0;
		opb_d   = instr.src2_value;
		wdata_d = '0;
		alt_d   = 1'b0;
		unique case (opc)
			OPC_LUI: begin
				cls_d = CLS_LUI;
				imm_d = imm_u;
			end
			OPC_AUIPC: begin
				cls_d  = CLS_AUIPC;
				base_d = instr.cur_pc;
				imm_d  = imm_u;
			end
			OPC_JAL: begin
				cls_d  = CLS_JAL;
				base_d = instr.cur_pc;
				imm_d  = imm_j;
			end
			OPC_JALR: begin
				if (f3 == F3_ADD) cls_d = CLS_JALR;
				base_d = instr.src1_value;
				imm_d  = imm_i;
			end
			OPC_BRANCH: begin
				if (f3 != F3_SLT && f3 != F3_SLTU) cls_d = CLS_BRANCH;
				base_d = instr.cur_pc;
				imm_d  = imm_b;
			end
			OPC_LOAD: begin
				cls_d  = CLS_LOAD;
				base_d = instr.src1_value;
				imm_d  = imm_i;
				unique case (f3)
					F3_B:    mop_d = MOP_LB;
					F3_H:    mop_d = MOP_LH;
					F3_W:    mop_d = MOP_LW;
					F3_BU:   mop_d = MOP_LBU;
					F3_HU:   mop_d = MOP_LHU;
					default: cls_d = CLS_ILLEGAL;
				endcase
			end
			OPC_STORE: begin
				cls_d  = CLS_STORE;
				base_d = instr.src1_value;
				imm_d  = imm_s;
				unique case (f3)
					F3_B: begin
						mop_d   = MOP_SB;
						wdata_d = {24'h0, instr.src2_value[7:0]};
					end
					F3_H: begin
						mop_d   = MOP_SH;
						wdata_d = {16'h0, instr.src2_value[15:0]};
					end
					F3_W: begin
						mop_d   = MOP_SW;
						wdata_d = instr.src2_value;
					end
					default: cls_d = CLS_ILLEGAL;
				endcase
			end
			OPC_OPIMM: begin
				opb_d = imm_i;
				// shift immediates need a clear upper field; SRAI is not supported
				if ((f3 != F3_SLL && f3 != F3_SR) || f7 == F7_BASE) cls_d = CLS_ALU;
			end
			OPC_OP: begin
				if (f7 == F7_BASE) begin
					cls_d = CLS_ALU;
				end else if (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR)) begin
					cls_d = CLS_ALU;
					alt_d = 1'b1;
				end
			end
			default: cls_d = CLS_ILLEGAL;
		endcase
	end

	cls_t        cls_s1;
	logic [2:0]  f3_s1;
	logic        alt_s1;
	logic [4:0]  rd_s1;
	logic [31:0] a_s1, b_s1, opb_s1, pc_s1, base_s1, imm_s1, wdata_s1;
	logic [3:0]  mop_s1;

	always_ff @(posedge clk) begin
		if (ready_s1 && instr.valid) begin
			cls_s1   <= cls_d;
			f3_s1    <= f3;
			alt_s1   <= alt_d;
			rd_s1    <= iw[11:7];
			a_s1     <= instr.src1_value;
			b_s1     <= instr.src2_value;
			opb_s1   <= opb_d;
			pc_s1    <= instr.cur_pc;
			base_s1  <= base_d;
			imm_s1   <= imm_d;
			mop_s1   <= mop_d;
			wdata_s1 <= wdata_d;
		end
	end

	// ---------------- Stage 2: execute ----------------
	logic [4:0]  shamt;
	logic [31:0] alu_x;
	logic        take_x;

	assign shamt = opb_s1[4:0];

	always_comb begin
		unique case (f3_s1)
			F3_ADD:  alu_x = alt_s1 ? a_s1 - opb_s1 : a_s1 + opb_s1;
			F3_SLL:  alu_x = a_s1 << shamt;
			F3_SLT:  alu_x = {31'h0, $signed(a_s1) < $signed(opb_s1)};
			F3_SLTU: alu_x = {31'h0, a_s1 < opb_s1};
			F3_XOR:  alu_x = a_s1 ^ opb_s1;
			F3_SR:   alu_x = alt_s1 ? 32'($signed(a_s1) >>> shamt) : a_s1 >> shamt;
			F3_OR:   alu_x = a_s1 | opb_s1;
			F3_AND:  alu_x = a_s1 & opb_s1;
			default: alu_x = '0;
		endcase
	end

	// Branch condition
	always_comb begin
		unique case (f3_s1)
			F3_BEQ:  take_x = a_s1 == b_s1;
			F3_BNE:  take_x = a_s1 != b_s1;
			F3_BLT:  take_x = $signed(a_s1) < $signed(b_s1);
			F3_BGE:  take_x = !($signed(a_s1) < $signed(b_s1));
			F3_BLTU: take_x = a_s1 < b_s1;
			F3_BGEU: take_x = !(a_s1 < b_s1);
			default: take_x = 1'b0;
		endcase
	end

	cls_t        cls_s2;
	logic [4:0]  rd_s2;
	logic [31:0] alu_s2, sum_s2, seq_s2, wdata_s2;
	logic        take_s2;
	logic [3:0]  mop_s2;

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			cls_s2   <= cls_s1;
			rd_s2    <= rd_s1;
			alu_s2   <= alu_x;
			sum_s2   <= base_s1 + imm_s1;
			seq_s2   <= pc_s1 + 32'd4;
			take_s2  <= take_x;
			mop_s2   <= mop_s1;
			wdata_s2 <= wdata_s1;
		end
	end

	// ---------------- Stage 3: result select ----------------
	logic        wr_x;
	logic [31:0] val_x, next_x, addr_x, wd_x;
	logic [3:0]  mop_x;

	always_comb begin
		wr_x   = 1'b0;
		val_x  = '0;
		next_x = seq_s2;
		addr_x = '0;
		wd_x   = '0;
		mop_x  = MOP_NONE;
		unique case (cls_s2)
			CLS_LUI, CLS_AUIPC: begin
				wr_x  = 1'b1;
				val_x = sum_s2;
			end
			CLS_JAL: begin
				wr_x   = 1'b1;
				val_x  = seq_s2;
				next_x = sum_s2;
			end
			CLS_JALR: begin
				wr_x   = 1'b1;
				val_x  = seq_s2;
				next_x = {sum_s2[31:1], 1'b0};
			end
			CLS_BRANCH: begin
				if (take_s2) next_x = sum_s2;
			end
			CLS_LOAD: begin
				mop_x  = mop_s2;
				addr_x = sum_s2;
			end
			CLS_STORE: begin
				mop_x  = mop_s2;
				addr_x = sum_s2;
				wd_x   = wdata_s2;
			end
			CLS_ALU: begin
				wr_x  = 1'b1;
				val_x = alu_s2;
			end
			default: begin
				wr_x = 1'b0;
			end
		endcase
		// x0 is never written
		if (rd_s2 == 5'd0) begin
			wr_x  = 1'b0;
			val_x = '0;
		end
	end

	logic [4:0]  dest_index_s3;
	logic        dest_write_s3, illegal_s3;
	logic [31:0] dest_value_s3, next_pc_s3, mem_address_s3, mem_write_data_s3;
	logic [3:0]  mem_op_s3;

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			dest_index_s3     <= rd_s2;
			dest_write_s3     <= wr_x;
			dest_value_s3     <= val_x;
			next_pc_s3        <= next_x;
			mem_op_s3         <= mop_x;
			mem_address_s3    <= addr_x;
			mem_write_data_s3 <= wd_x;
			illegal_s3        <= cls_s2 == CLS_ILLEGAL;
		end
	end

	assign result.valid          = valid_s3;
	assign result.dest_index     = dest_index_s3;
	assign result.dest_write     = dest_write_s3;
	assign result.dest_value     = dest_value_s3;
	assign result.next_pc        = next_pc_s3;
	assign result.mem_op         = mem_op_s3;
	assign result.mem_address    = mem_address_s3;
	assign result.mem_write_data = mem_write_data_s3;
	assign result.illegal        = illegal_s3;

`ifndef SYNTHESIS
	// Rejected encodings produce no register write and no memory request
	a_illegal_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.illegal |-> !result.dest_write && result.mem_op == MOP_NONE)
		else $error("illegal word carries a side effect");

	// x0 is never a write target
	a_no_x0_write: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.dest_write |-> result.dest_index != 5'd0)
		else $error("write to x0");

	// Full pipeline with a stalled output must refuse new words
	a_full_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && valid_s3 && !result.ready |-> !instr.ready)
		else $error("word accepted into a full pipeline");
`endif

endmodule

`default_nettype wire
